// File: sv/rqmt_pkg.sv
`default_nettype none
package rqmt_pkg;

   localparam int SLOTS      = 6;
   localparam int VALUE_BITS = 12;

   // Fixed widths of the result fields.
   localparam int MEAN_BITS = 12;
   localparam int OCC_BITS  = 3;

   localparam int PTR_BITS     = $clog2(SLOTS);
   localparam int CNT_BITS     = $clog2(SLOTS);
   localparam int SUM_BITS     = VALUE_BITS + $clog2(SLOTS);
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [VALUE_BITS-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0]    mean;
      logic [MEAN_BITS-1:0]    popped;
      logic                    popped_valid;
      logic [OCC_BITS-1:0]     occupancy;
   } rsp_type;

   typedef struct packed {
      logic                    start;
      logic [SUM_BITS-1:0]     dividend;
      logic [CNT_BITS-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [SUM_BITS-1:0]     quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: sv/rqmt_div.sv
`default_nettype none
module rqmt_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rqmt_pkg::div_req_type div_req,
   output rqmt_pkg::div_rsp_type      div_rsp
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [rqmt_pkg::DIV_CNT_BITS-1:0]      count_ff, count_in;
   logic [rqmt_pkg::CNT_BITS-1:0]          rem_ff, rem_in;
   logic [rqmt_pkg::SUM_BITS-1:0]          quo_ff, quo_in;
   logic [rqmt_pkg::CNT_BITS-1:0]          div_ff, div_in;
   logic [rqmt_pkg::CNT_BITS:0]            rem_shift;
   logic [rqmt_pkg::CNT_BITS:0]            diff;
   logic                                   fits;

   // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[rqmt_pkg::SUM_BITS-1]};
      diff      = rem_shift - {1'b0, div_ff};
      fits      = (rem_shift >= {1'b0, div_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = rqmt_pkg::DIV_CNT_BITS'(rqmt_pkg::SUM_BITS);
         rem_in   = '0;
         quo_in   = div_req.dividend;
         div_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[rqmt_pkg::CNT_BITS-1:0] : rem_shift[rqmt_pkg::CNT_BITS-1:0];
         quo_in   = {quo_ff[rqmt_pkg::SUM_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == rqmt_pkg::DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// File: sv/ring_queue_mean_tracker.sv
`default_nettype none
// Ring queue that keeps up to SLOTS-1 values, drops the oldest when an insert finds it
// full, and answers every request with one response. An insert answers with the truncated
// mean of the stored values and passes from acceptance to the response register through
// the slot read and the queue update, the radix-2 divider (one quotient bit per cycle
// over the 15-bit running sum), the hand-back of the quotient and the load of the
// response. A remove skips the divider. One request is in work at a time; the next is
// taken in the cycle after the previous one has reached the response register, even
// while that response is still stalled.
module ring_queue_mean_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rqmt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rqmt_pkg::rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   localparam logic [rqmt_pkg::PTR_BITS-1:0] LAST_PTR = rqmt_pkg::PTR_BITS'(rqmt_pkg::SLOTS - 1);
   localparam logic [rqmt_pkg::CNT_BITS-1:0] FULL_CNT = rqmt_pkg::CNT_BITS'(rqmt_pkg::SLOTS - 1);

   state_type                        state_ff, state_in;
   logic [rqmt_pkg::PTR_BITS-1:0]    head_ff, head_in;
   logic [rqmt_pkg::PTR_BITS-1:0]    tail_ff, tail_in;
   logic [rqmt_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [rqmt_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   rqmt_pkg::req_type                item_ff, item_in;
   rqmt_pkg::rsp_type                res_ff, res_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rqmt_pkg::rsp_type                rsp_ff, rsp_in;
   logic [rqmt_pkg::VALUE_BITS-1:0]  slot_store [rqmt_pkg::SLOTS];
   logic [rqmt_pkg::VALUE_BITS-1:0]  rd_ff;
   logic                             wr_en;
   logic                             full;
   logic                             accept;
   rqmt_pkg::div_req_type            div_req;
   rqmt_pkg::div_rsp_type            div_rsp;

   function automatic logic [rqmt_pkg::PTR_BITS-1:0] step_ptr(
      input logic [rqmt_pkg::PTR_BITS-1:0] p
   );
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   rqmt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (cnt_ff == FULL_CNT);

   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      cnt_in           = cnt_ff;
      sum_in           = sum_ff;
      item_in          = item_ff;
      res_in           = res_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_in           = rsp_ff;
      wr_en            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // The oldest slot has been read into rd_ff by now.
            res_in = '0;
            if (item_ff.kind == rqmt_pkg::KIND_INSERT) begin
               wr_en   = 1'b1;
               tail_in = step_ptr(tail_ff);
               if (full) begin
                  head_in = step_ptr(head_ff);
                  sum_in  = sum_ff - rqmt_pkg::SUM_BITS'(rd_ff)
                            + rqmt_pkg::SUM_BITS'(item_ff.value);
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  sum_in = sum_ff + rqmt_pkg::SUM_BITS'(item_ff.value);
               end
               div_req.start    = 1'b1;
               div_req.dividend = sum_in;
               div_req.divisor  = cnt_in;
               res_in.occupancy = rqmt_pkg::OCC_BITS'(cnt_in);
               state_in         = ST_DIV;
            end else begin
               if (cnt_ff != '0) begin
                  head_in             = step_ptr(head_ff);
                  cnt_in              = cnt_ff - 1'b1;
                  sum_in              = sum_ff - rqmt_pkg::SUM_BITS'(rd_ff);
                  res_in.popped       = rqmt_pkg::MEAN_BITS'(rd_ff);
                  res_in.popped_valid = 1'b1;
               end
               res_in.occupancy = rqmt_pkg::OCC_BITS'(cnt_in);
               state_in         = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_in.mean = rqmt_pkg::MEAN_BITS'(div_rsp.quotient);
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_store[tail_ff] <= item_ff.value;
      end
      rd_ff <= slot_store[head_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue count beyond capacity");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) == (head_ff == tail_ff))
      else $error("pointers disagree with queue count");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted request did not go to slot read");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside of the divide state");

   a_pop_no_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.popped_valid) |-> rsp_data.mean == '0)
      else $error("remove response carries a mean");

endmodule
`default_nettype wire
